@@ rtl/core/dte_pkg.sv @@
`default_nettype none

package dte_pkg;

  localparam int YearW   = 12;
  localparam int MonthW  = 4;
  localparam int DayW    = 5;
  localparam int HourW   = 5;
  localparam int MinW    = 6;
  localparam int SecW    = 6;
  localparam int EpochW  = 37;
  localparam int DaysW   = 22;
  localparam int TodW    = 17;
  localparam int LeapW   = 10;
  localparam int DbmW    = 9;
  localparam int QuoW    = 6;
  localparam int ProdW   = 25;
  localparam int InDataW  = 40;
  localparam int OutDataW = 40;
  localparam int InPadW   = InDataW - (YearW + MonthW + DayW + HourW + MinW + SecW);

  localparam logic [YearW-1:0]  YearMax   = 12'd3000;
  localparam logic [YearW:0]    EpochYear = 13'd2015;
  localparam logic [MonthW-1:0] MonthFeb  = 4'd1;
  localparam logic [MonthW-1:0] MonthLast = 4'd11;
  localparam logic [HourW-1:0]  HourMax   = 5'd24;
  localparam logic [MinW-1:0]   MinMax    = 6'd60;
  localparam logic [SecW-1:0]   SecMax    = 6'd60;

  // floor(y / 100) for y < 4096 as (y * 5243) >> 19
  localparam logic [12:0] Div100Recip = 13'd5243;
  localparam int          Div100Shift = 19;
  localparam logic [YearW-1:0] Century = 12'd100;

  localparam logic signed [DaysW-1:0] DaysPerYear = 22'sd365;
  // leap days below the epoch year plus the one-based day offset
  localparam logic signed [DaysW-1:0] DaysBias    = 22'sd490;
  localparam logic signed [DaysW+TodW-1:0] SecsPerDay = 39'sd86400;
  localparam logic [TodW-1:0] SecsPerHour = 17'd3600;
  localparam logic [TodW-1:0] SecsPerMin  = 17'd60;

  typedef struct packed {
    logic [InPadW-1:0] pad;
    logic [SecW-1:0]   second;
    logic [MinW-1:0]   minute;
    logic [HourW-1:0]  hour;
    logic [DayW-1:0]   day;
    logic [MonthW-1:0] month;
    logic [YearW-1:0]  year;
  } date_t;

  typedef struct packed {
    date_t           date;
    logic [QuoW-1:0] q100;
    logic            range_ok;
  } s1_t;

  typedef struct packed {
    logic [YearW-1:0] year;
    logic [LeapW-1:0] leaps;
    logic [DbmW-1:0]  dbm;
    logic [DayW-1:0]  day;
    logic [HourW-1:0] hour;
    logic [MinW-1:0]  minute;
    logic [SecW-1:0]  second;
    logic             ok;
  } s2_t;

  typedef struct packed {
    logic signed [DaysW-1:0] days;
    logic [TodW-1:0]         tod;
    logic                    ok;
  } s3_t;

  function automatic logic [DbmW-1:0] days_before(input logic [MonthW-1:0] m);
    logic [DbmW-1:0] r;
    case (m)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd31;
      4'd2:    r = 9'd59;
      4'd3:    r = 9'd90;
      4'd4:    r = 9'd120;
      4'd5:    r = 9'd151;
      4'd6:    r = 9'd181;
      4'd7:    r = 9'd212;
      4'd8:    r = 9'd243;
      4'd9:    r = 9'd273;
      4'd10:   r = 9'd304;
      4'd11:   r = 9'd334;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  function automatic logic [DayW-1:0] month_days(input logic [MonthW-1:0] m);
    logic [DayW-1:0] r;
    case (m)
      4'd1:                  r = 5'd28;
      4'd3, 4'd5, 4'd8, 4'd10: r = 5'd30;
      default:               r = 5'd31;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/calendar_date_to_epoch_seconds_top.sv @@
// channel   dir  payload
// s_axis    in   tdata: year 12, month 4, day 5, hour 5, minute 6, second 6, zero pad 2
// m_axis    out  tdata: epoch seconds 37 signed, zero pad 3; tuser: date valid
//
// One request per cycle while the output is not stalled; each passes through every stage below.
// The depth is set by the divide-by-100, leap/month, day-count and
// seconds-multiply stages, one register each.
// Reset clears the stage valid bits only.
// A stalled output holds; upstream stages keep filling bubbles.
`default_nettype none

module calendar_date_to_epoch_seconds_top (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // year[11:0] month[15:12] day[20:16] hour[25:21] minute[31:26] second[37:32]
  input  wire logic [dte_pkg::InDataW-1:0]    s_axis_tdata_i,
  output logic                                m_axis_tvalid_o,
  input  wire logic                           m_axis_tready_i,
  // epoch_seconds[36:0]
  output logic [dte_pkg::OutDataW-1:0]        m_axis_tdata_o,
  // date_valid[0]
  output logic                                m_axis_tuser_o
);
  import dte_pkg::*;

  logic                     v2, r2, v3, r3;
  s2_t                      st2;
  s3_t                      st3;
  logic signed [EpochW-1:0] epoch;

  dte_leap u_leap (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid_i),
    .ready_o (s_axis_tready_o),
    .date_i  (date_t'(s_axis_tdata_i)),
    .valid_o (v2),
    .ready_i (r2),
    .stage_o (st2)
  );

  dte_days u_days (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v2),
    .ready_o (r2),
    .stage_i (st2),
    .valid_o (v3),
    .ready_i (r3),
    .stage_o (st3)
  );

  dte_scale u_scale (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v3),
    .ready_o (r3),
    .stage_i (st3),
    .valid_o (m_axis_tvalid_o),
    .ready_i (m_axis_tready_i),
    .epoch_o (epoch),
    .ok_o    (m_axis_tuser_o)
  );

  assign m_axis_tdata_o = {{(OutDataW-EpochW){1'b0}}, epoch};

`ifndef SYNTHESIS
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o |-> epoch == '0)
    else $error("invalid date gave nonzero seconds");

  a_full_when_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> v2 && v3 && m_axis_tvalid_o)
    else $error("input blocked with a free stage");

  a_result_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |->
      (epoch >= -37'sd63587289600) && (epoch <= 37'sd31115149260))
    else $error("seconds out of range");
`endif

endmodule

`default_nettype wire

@@ rtl/core/dte_leap.sv @@
`default_nettype none

module dte_leap (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          valid_i,
  output logic               ready_o,
  input  wire dte_pkg::date_t date_i,
  output logic               valid_o,
  input  wire logic          ready_i,
  output dte_pkg::s2_t       stage_o
);
  import dte_pkg::*;

  logic            v1_q, v2_q;
  logic            rdy1, rdy2;
  s1_t             s1_d, s1_q;
  s2_t             s2_d, s2_q;
  logic [ProdW-1:0] prod;
  logic [YearW-1:0] cent;
  logic            leap;
  logic [YearW-1:0] lsum;
  logic [DayW-1:0]  mlen;
  logic            day_ok;

  assign rdy2    = !v2_q || ready_i;
  assign rdy1    = !v1_q || rdy2;
  assign ready_o = rdy1;
  assign valid_o = v2_q;
  assign stage_o = s2_q;

  // stage 1: century quotient and plain range checks
  always_comb begin
    prod          = ProdW'(date_i.year) * ProdW'(Div100Recip);
    s1_d.date     = date_i;
    s1_d.q100     = prod[Div100Shift +: QuoW];
    s1_d.range_ok = (date_i.year <= YearMax) && (date_i.month <= MonthLast) &&
                    (date_i.hour <= HourMax) && (date_i.minute <= MinMax) &&
                    (date_i.second <= SecMax);
  end

  // stage 2: leap flag, leap days below the year, month offset, day check
  always_comb begin
    cent   = YearW'(s1_q.q100) * Century;
    leap   = (s1_q.date.year[1:0] == 2'd0) &&
             ((s1_q.date.year != cent) || (s1_q.q100[1:0] == 2'd0));
    lsum   = (s1_q.date.year >> 2) - YearW'(s1_q.q100) + YearW'(s1_q.q100 >> 2)
             + 12'd1 - YearW'(leap);
    mlen   = month_days(s1_q.date.month) +
             DayW'(leap && (s1_q.date.month == MonthFeb));
    day_ok = (s1_q.date.day != '0) && (s1_q.date.day <= mlen);
    s2_d.year   = s1_q.date.year;
    s2_d.leaps  = lsum[LeapW-1:0];
    s2_d.dbm    = days_before(s1_q.date.month) +
                  DbmW'(leap && (s1_q.date.month > MonthFeb));
    s2_d.day    = s1_q.date.day;
    s2_d.hour   = s1_q.date.hour;
    s2_d.minute = s1_q.date.minute;
    s2_d.second = s1_q.date.second;
    s2_d.ok     = s1_q.range_ok && day_ok;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= valid_i;
      if (rdy2) v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && rdy1) s1_q <= s1_d;
    if (v1_q && rdy2)    s2_q <= s2_d;
  end

endmodule

`default_nettype wire

@@ rtl/core/dte_days.sv @@
`default_nettype none

module dte_days (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        valid_i,
  output logic             ready_o,
  input  wire dte_pkg::s2_t stage_i,
  output logic             valid_o,
  input  wire logic        ready_i,
  output dte_pkg::s3_t     stage_o
);
  import dte_pkg::*;

  logic                    v_q;
  s3_t                     s3_d, s3_q;
  logic signed [YearW:0]   yd;
  logic signed [DaysW-1:0] ymul;

  assign ready_o = !v_q || ready_i;
  assign valid_o = v_q;
  assign stage_o = s3_q;

  always_comb begin
    yd        = $signed({1'b0, stage_i.year} - EpochYear);
    ymul      = {{(DaysW-YearW-1){yd[YearW]}}, yd} * DaysPerYear;
    s3_d.days = ymul + $signed({{(DaysW-LeapW){1'b0}}, stage_i.leaps})
                     + $signed({{(DaysW-DbmW){1'b0}}, stage_i.dbm})
                     + $signed({{(DaysW-DayW){1'b0}}, stage_i.day})
                     - DaysBias;
    s3_d.tod  = TodW'(stage_i.hour) * SecsPerHour + TodW'(stage_i.minute) * SecsPerMin
                + TodW'(stage_i.second);
    s3_d.ok   = stage_i.ok;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (ready_o) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) s3_q <= s3_d;
  end

endmodule

`default_nettype wire

@@ rtl/core/dte_scale.sv @@
`default_nettype none

module dte_scale (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          valid_i,
  output logic                               ready_o,
  input  wire dte_pkg::s3_t                  stage_i,
  output logic                               valid_o,
  input  wire logic                          ready_i,
  output logic signed [dte_pkg::EpochW-1:0]  epoch_o,
  output logic                               ok_o
);
  import dte_pkg::*;

  logic                          v_q;
  logic signed [EpochW-1:0]      epoch_d, epoch_q;
  logic                          ok_q;
  logic signed [DaysW+TodW-1:0]  prod;

  assign ready_o = !v_q || ready_i;
  assign valid_o = v_q;
  assign epoch_o = epoch_q;
  assign ok_o    = ok_q;

  always_comb begin
    prod    = {{TodW{stage_i.days[DaysW-1]}}, stage_i.days} * SecsPerDay
              + $signed({{DaysW{1'b0}}, stage_i.tod});
    epoch_d = stage_i.ok ? prod[EpochW-1:0] : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (ready_o) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      epoch_q <= epoch_d;
      ok_q    <= stage_i.ok;
    end
  end

endmodule

`default_nettype wire

@@ test/testbench.sv @@
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NumDirected = 22;
  localparam int NumRandom   = 1530;
  localparam int HoldCycles  = 300;
  localparam int CycleLimit  = 400000;
  localparam int YearTop     = 3000;
  localparam int MonthTop    = 11;
  localparam int EpochBase   = 2015;
  localparam int PadW        = dte_pkg::OutDataW - dte_pkg::EpochW;
  localparam int InBits      = dte_pkg::InDataW;
  localparam int YearBits    = dte_pkg::YearW;
  localparam int MonthBits   = dte_pkg::MonthW;
  localparam int DayBits     = dte_pkg::DayW;
  localparam int HourBits    = dte_pkg::HourW;
  localparam int MinBits     = dte_pkg::MinW;
  localparam int SecBits     = dte_pkg::SecW;

  typedef struct packed {
    logic [dte_pkg::EpochW-1:0] secs;
    logic                       ok;
  } stamp_t;

  typedef struct {
    int     year;
    int     month;
    int     day;
    int     hour;
    int     minute;
    int     second;
    bit     known;
    longint want_secs;
    bit     want_ok;
  } row_t;

  logic                        clk_i = 1'b0;
  logic                        rst_ni = 1'b0;
  logic                        s_axis_tvalid_i = 1'b0;
  logic                        s_axis_tready_o;
  logic [dte_pkg::InDataW-1:0] s_axis_tdata_i = '0;
  logic                        m_axis_tvalid_o;
  logic                        m_axis_tready_i = 1'b0;
  logic [dte_pkg::OutDataW-1:0] m_axis_tdata_o;
  logic                        m_axis_tuser_o;

  stamp_t pending_stamps[$];
  int     errors = 0;
  int     sent = 0;
  int     valid_seen = 0;
  int     rejected_seen = 0;
  int     cycle_count = 0;
  int     input_stalls = 0;
  bit     send_burst = 1'b0;
  bit     stall_out = 1'b0;

  calendar_date_to_epoch_seconds_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o)
  );

  always #1 clk_i = ~clk_i;

  function automatic bit is_leap(input int y);
    return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
  endfunction

  function automatic int days_in_month(input int y, input int m);
    int r;
    case (m)
      1: begin
        r = is_leap(y) ? 29 : 28;
      end
      3, 5, 8, 10: begin
        r = 30;
      end
      default: begin
        r = 31;
      end
    endcase
    return r;
  endfunction

  // leap years in [0, y), year 0 included
  function automatic longint leap_days_before(input longint y);
    return (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400;
  endfunction

  function automatic stamp_t epoch_of(input dte_pkg::date_t d);
    stamp_t r;
    longint yy, dd, hh, mi, ss, days, secs;
    bit ok;
    yy = d.year;
    dd = d.day;
    hh = d.hour;
    mi = d.minute;
    ss = d.second;
    r = '0;
    ok = (yy <= YearTop) && (d.month <= MonthTop) && (dd >= 1) &&
         (hh <= 24) && (mi <= 60) && (ss <= 60);
    if (ok) begin
      ok = dd <= days_in_month(int'(yy), int'(d.month));
    end
    if (ok) begin
      days = (yy - EpochBase) * 365 + leap_days_before(yy) - leap_days_before(EpochBase);
      for (int k = 0; k < int'(d.month); k++) begin
        days += days_in_month(int'(yy), k);
      end
      days += dd - 1;
      secs = days * 86400 + hh * 3600 + mi * 60 + ss;
      r.secs = secs[dte_pkg::EpochW-1:0];
      r.ok = 1'b1;
    end
    return r;
  endfunction

  function automatic dte_pkg::date_t well_formed_date();
    dte_pkg::date_t d;
    int mlen;
    d = '0;
    case ($urandom_range(0, 7))
      0: begin
        d.year = YearBits'($urandom_range(0, 1) ? $urandom_range(0, 3)
                                                : $urandom_range(2997, 3000));
      end
      1: begin
        d.year = YearBits'($urandom_range(0, 30) * 100);
      end
      2: begin
        d.year = YearBits'($urandom_range(2005, 2025));
      end
      default: begin
        d.year = YearBits'($urandom_range(0, YearTop));
      end
    endcase
    d.month = MonthBits'($urandom_range(0, MonthTop));
    mlen = days_in_month(int'(d.year), int'(d.month));
    d.day = DayBits'(($urandom_range(0, 3) == 0) ? mlen : $urandom_range(1, mlen));
    d.hour = HourBits'($urandom_range(0, 24));
    d.minute = MinBits'($urandom_range(0, 60));
    d.second = SecBits'($urandom_range(0, 60));
    return d;
  endfunction

  // push exactly one field out of range
  function automatic dte_pkg::date_t broken_date();
    dte_pkg::date_t d;
    int mlen;
    d = well_formed_date();
    mlen = days_in_month(int'(d.year), int'(d.month));
    case ($urandom_range(0, 5))
      0: begin
        d.year = YearBits'($urandom_range(YearTop + 1, 4095));
      end
      1: begin
        d.month = MonthBits'($urandom_range(MonthTop + 1, 15));
      end
      2: begin
        d.day = DayBits'((mlen == 31 || $urandom_range(0, 1)) ? 0
                                                               : $urandom_range(mlen + 1, 31));
      end
      3: begin
        d.hour = HourBits'($urandom_range(25, 31));
      end
      4: begin
        d.minute = MinBits'($urandom_range(61, 63));
      end
      default: begin
        d.second = SecBits'($urandom_range(61, 63));
      end
    endcase
    return d;
  endfunction

  function automatic dte_pkg::date_t noise_date();
    dte_pkg::date_t d;
    d = '0;
    d.year = YearBits'($urandom);
    d.month = MonthBits'($urandom);
    d.day = DayBits'($urandom);
    d.hour = HourBits'($urandom);
    d.minute = MinBits'($urandom);
    d.second = SecBits'($urandom);
    return d;
  endfunction

  task automatic flag_error(input string what);
    errors++;
    if (errors <= 10) begin
      $display("mismatch %0d: %s", errors, what);
    end
  endtask

  task automatic offer(input dte_pkg::date_t d, input bit known, input stamp_t typed_stamp);
    int gap;
    if (sent % 64 == 0) begin
      send_burst = ($urandom_range(0, 2) == 0);
    end
    gap = (send_burst || stall_out) ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      s_axis_tdata_i <= InBits'({$urandom, $urandom});
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tdata_i <= d;
    s_axis_tvalid_i <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    pending_stamps.push_back(known ? typed_stamp : epoch_of(d));
    sent++;
  endtask

  always @(posedge clk_i) begin : check_out
    stamp_t w;
    if (m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_stamps.size() == 0) begin
        flag_error($sformatf("result tdata %h tuser %b with no request pending",
                             m_axis_tdata_o, m_axis_tuser_o));
      end else begin
        w = pending_stamps.pop_front();
        if (w.ok) valid_seen++;
        else rejected_seen++;
        if (m_axis_tdata_o !== {{PadW{1'b0}}, w.secs} || m_axis_tuser_o !== w.ok) begin
          flag_error($sformatf("expected seconds %0d valid %b, got %0d valid %b (tdata %h)",
                               $signed(w.secs), w.ok,
                               $signed(m_axis_tdata_o[dte_pkg::EpochW-1:0]),
                               m_axis_tuser_o, m_axis_tdata_o));
        end
      end
    end
  end

  initial begin : drain_side
    int gap;
    int taken;
    bit burst;
    taken = 0;
    burst = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if (taken % 64 == 0) begin
        burst = ($urandom_range(0, 2) == 0);
      end
      gap = burst ? 0 : $urandom_range(0, 17);
      // hold the output once so the pipeline fills and stalls its input
      if (taken == 250) begin
        gap = HoldCycles;
        stall_out = 1'b1;
      end
      if (gap > 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      stall_out = 1'b0;
      m_axis_tready_i <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid_o) @(posedge clk_i);
      taken++;
    end
  end

  initial begin : watchdog
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
      if (s_axis_tvalid_i && !s_axis_tready_o) input_stalls++;
    end
    $display("timeout after %0d cycles, %0d results outstanding",
             cycle_count, pending_stamps.size());
    $display("CHECK FAILED");
    $finish;
  end

  initial begin : stimulus
    row_t plan [NumDirected];
    dte_pkg::date_t d;
    stamp_t w;
    int pick;
    plan = '{
      '{2015,  0,  1,  0,  0,  0, 1'b1, 64'sd0,            1'b1},
      '{2015,  0,  1,  0,  0,  1, 1'b1, 64'sd1,            1'b1},
      '{2015,  0,  1, 24,  0,  0, 1'b1, 64'sd86400,        1'b1},
      '{2014, 11, 31, 23, 59, 59, 1'b1, -64'sd1,           1'b1},
      '{   0,  0,  1,  0,  0,  0, 1'b1, -64'sd63587289600, 1'b1},
      '{3000, 11, 31, 24, 60, 60, 1'b1, 64'sd31115149260,  1'b1},
      '{3001,  0,  1,  0,  0,  0, 1'b1, 64'sd0,            1'b0},
      '{4095, 15, 31, 31, 63, 63, 1'b1, 64'sd0,            1'b0},
      '{2020, 12,  1,  0,  0,  0, 1'b1, 64'sd0,            1'b0},
      '{2020,  0,  0,  0,  0,  0, 1'b1, 64'sd0,            1'b0},
      '{2021,  3, 31,  0,  0,  0, 1'b1, 64'sd0,            1'b0},
      '{2015,  1, 29,  0,  0,  0, 1'b1, 64'sd0,            1'b0},
      '{1900,  1, 29,  0,  0,  0, 1'b1, 64'sd0,            1'b0},
      '{2015,  5, 15, 25,  0,  0, 1'b1, 64'sd0,            1'b0},
      '{2015,  5, 15,  0, 61,  0, 1'b1, 64'sd0,            1'b0},
      '{2015,  5, 15,  0,  0, 61, 1'b1, 64'sd0,            1'b0},
      '{2016,  1, 29, 12,  0,  0, 1'b0, 64'sd0,            1'b0},
      '{2000,  1, 29,  0,  0,  0, 1'b0, 64'sd0,            1'b0},
      '{   0,  1, 29,  0,  0,  0, 1'b0, 64'sd0,            1'b0},
      '{2016,  2,  1,  0,  0,  0, 1'b0, 64'sd0,            1'b0},
      '{2100,  1, 28, 23, 59, 59, 1'b0, 64'sd0,            1'b0},
      '{2016, 11, 31, 24, 60, 60, 1'b0, 64'sd0,            1'b0}
    };
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    foreach (plan[i]) begin
      d = '0;
      d.year = YearBits'(plan[i].year);
      d.month = MonthBits'(plan[i].month);
      d.day = DayBits'(plan[i].day);
      d.hour = HourBits'(plan[i].hour);
      d.minute = MinBits'(plan[i].minute);
      d.second = SecBits'(plan[i].second);
      w.secs = plan[i].want_secs[dte_pkg::EpochW-1:0];
      w.ok = plan[i].want_ok;
      offer(d, plan[i].known, w);
    end
    for (int n = 0; n < NumRandom; n++) begin
      pick = $urandom_range(0, 19);
      if (pick < 15) d = well_formed_date();
      else if (pick < 18) d = broken_date();
      else d = noise_date();
      offer(d, 1'b0, '0);
    end
    s_axis_tvalid_i <= 1'b0;
    while (pending_stamps.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    $display("Sent %0d dates (%0d from the table, the rest random): %0d valid, %0d rejected.",
             sent, NumDirected, valid_seen, rejected_seen);
    $display("Output held off once for %0d cycles; input back-pressured on %0d cycles.",
             HoldCycles, input_stalls);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches", errors);
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/dte_pkg.sv
rtl/core/dte_leap.sv
rtl/core/dte_days.sv
rtl/core/dte_scale.sv
rtl/core/calendar_date_to_epoch_seconds_top.sv
test/testbench.sv
